/* rtl/dzne_pkg.sv */
// ----------------------------------------------------------------------------
// Depth zero-neighbor erosion: shared definitions
// Register indexes, field widths and the per-pixel position flags.
// ----------------------------------------------------------------------------
package dzne_pkg;

   // Widths of the configuration registers and the write port.
   localparam int COLCFG_W   = 10;
   localparam int ROW_W      = 12;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 12;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_COLUMNS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_ROWS    = 1'b1;

   // Smallest frame size along either axis.
   localparam int MIN_SIZE = 3;

   // Where a pixel sits in the frame, worked out when it is accepted.
   typedef struct packed {
      logic has_res;   // row one or later: the pixel above is sent out
      logic interior;  // the pixel above is an interior pixel
      logic last_row;  // the pixel itself is sent out as well
      logic last_col;  // final column of its row
   } pos_flags_type;

endpackage

/* rtl/dzne_line_mem.sv */
// ----------------------------------------------------------------------------
// Line buffer memory
// One write port and two read ports; read data is registered and held
// until the next read.
// ----------------------------------------------------------------------------
module dzne_line_mem #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Both read ports; the data stays put while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

/* rtl/depth_zero_neighbor_erosion.sv */
// ----------------------------------------------------------------------------
// Depth zero-neighbor erosion
// Clears interior depth pixels that touch a zero pixel, one row of delay.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock and gives one result per clock on all
// rows but the last while the result side does not stall; on the last row
// each pixel causes two results (the filtered pixel above it, then the pixel
// itself) through the single result port, and the next pixel waits for both.
// The first row of a frame gives no results. Both line buffers share one
// memory entry per column, read at the current and the next column when a
// pixel is accepted and written back from the pixel stage; the memory needs
// no clearing after reset. Frame size is to be written through the csr_ port
// while no results are pending (not enforced); it takes effect on the next pixel.

module depth_zero_neighbor_erosion
   import dzne_pkg::*;
#(
   parameter int MAX_COLUMNS = 512,
   parameter int DEPTH_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input pixels. tdata: depth_in.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((DEPTH_BITS+7)/8)*8-1:0]    req_tdata,
   // Results. tdata: depth_out. tlast: frame_end.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((DEPTH_BITS+7)/8)*8-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   // Configuration writes.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [CSR_ADDR_W-1:0]              csr_addr,
   input  logic [CSR_DATA_W-1:0]              csr_data
);

   localparam int TW = ((DEPTH_BITS + 7) / 8) * 8;
   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int EW = (CW + 1 > COLCFG_W) ? CW + 1 : COLCFG_W;
   localparam logic [EW-1:0]    MAX_COLS_E = EW'(MAX_COLUMNS);
   localparam logic [EW-1:0]    MIN_COLS_E = EW'(MIN_SIZE);
   localparam logic [ROW_W-1:0] MIN_ROWS   = ROW_W'(MIN_SIZE);

   // Configuration registers.
   logic [COLCFG_W-1:0] cfg_cols_ff;
   logic [ROW_W-1:0]    cfg_rows_ff;

   // Position of the next input pixel.
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Pixel stage: waits for the line buffer read data.
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_phase_ff, s1_phase_in;
   logic [DEPTH_BITS-1:0] s1_pix_ff;
   logic [CW-1:0]         s1_col_ff;
   pos_flags_type         s1_flags_ff;

   // Left-hand neighbors of the pixel in the stage.
   logic [DEPTH_BITS-1:0] left_ff, above_left_ff, two_left_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DEPTH_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [EW-1:0]    cols_ext, cols_eff, cols_m1;
   logic [ROW_W-1:0] rows_eff, rows_m1, r_sel;
   logic [CW-1:0]    c_sel, c_next;
   pos_flags_type    flags;
   logic             accept;

   logic [2*DEPTH_BITS-1:0] rd_cur, rd_next;
   logic [DEPTH_BITS-1:0]   above_c, two_c, above_n, two_n;
   logic                    hole;
   logic [DEPTH_BITS-1:0]   res;
   logic                    out_free, s1_first, step0, emit0, emit1, s1_done;

   // Configuration port takes every write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_cols_ff <= COLCFG_W'(320);
         cfg_rows_ff <= ROW_W'(240);
      end else if (csr_valid) begin
         case (csr_addr)
            CSR_FRAME_COLUMNS: cfg_cols_ff <= csr_data[COLCFG_W-1:0];
            CSR_FRAME_ROWS:    cfg_rows_ff <= csr_data[ROW_W-1:0];
            default:           cfg_rows_ff <= cfg_rows_ff;
         endcase
      end
   end

   // Effective frame size and the clamped position of the incoming pixel.
   always_comb begin
      cols_ext = EW'(cfg_cols_ff);
      if (cols_ext < MIN_COLS_E) begin
         cols_eff = MIN_COLS_E;
      end else if (cols_ext > MAX_COLS_E) begin
         cols_eff = MAX_COLS_E;
      end else begin
         cols_eff = cols_ext;
      end
      cols_m1  = cols_eff - EW'(1);
      rows_eff = (cfg_rows_ff < MIN_ROWS) ? MIN_ROWS : cfg_rows_ff;
      rows_m1  = rows_eff - ROW_W'(1);

      c_sel = (EW'(col_ff) < cols_m1) ? col_ff : cols_m1[CW-1:0];
      r_sel = (row_ff < rows_m1) ? row_ff : rows_m1;

      flags.last_col = (EW'(c_sel) == cols_m1);
      flags.last_row = (r_sel == rows_m1);
      flags.has_res  = (r_sel != '0);
      flags.interior = (r_sel >= ROW_W'(2)) && (c_sel != '0) && !flags.last_col;

      c_next = c_sel + CW'(1);
      if (flags.last_col) begin
         col_in = '0;
         row_in = flags.last_row ? '0 : r_sel + ROW_W'(1);
      end else begin
         col_in = c_next;
         row_in = r_sel;
      end
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line buffers: upper half holds row r-2, lower half row r-1.
   dzne_line_mem #(
      .WIDTH (2 * DEPTH_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_line_mem (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr_a (c_sel),
      .rd_addr_b (c_next),
      .rd_data_a (rd_cur),
      .rd_data_b (rd_next),
      .wr_en     (step0),
      .wr_addr   (s1_col_ff),
      .wr_data   ({above_c, s1_pix_ff})
   );

   assign above_c = rd_cur[DEPTH_BITS-1:0];
   assign two_c   = rd_cur[2*DEPTH_BITS-1:DEPTH_BITS];
   assign above_n = rd_next[DEPTH_BITS-1:0];
   assign two_n   = rd_next[2*DEPTH_BITS-1:DEPTH_BITS];

   // Erosion test on the seven neighbors of the pixel above.
   always_comb begin
      hole = (two_left_ff == '0) || (two_c == '0) || (two_n == '0) ||
             (above_left_ff == '0) || (above_n == '0) || (left_ff == '0) ||
             (s1_pix_ff == '0);
      res = (s1_flags_ff.interior && (above_c != '0) && hole) ? '0 : above_c;
   end

   // Stage sequencing: the first step writes back and emits the filtered
   // pixel, a second step on the last row emits the pixel itself.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      s1_first = s1_valid_ff && !s1_phase_ff;
      step0    = s1_first && (!s1_flags_ff.has_res || out_free);
      emit0    = s1_first && s1_flags_ff.has_res && out_free;
      emit1    = s1_valid_ff && s1_phase_ff && out_free;
      s1_done  = (s1_first && !s1_flags_ff.has_res) ||
                 (emit0 && !s1_flags_ff.last_row) || emit1;

      req_tready = !s1_valid_ff || s1_done;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (emit0 && s1_flags_ff.last_row) begin
         s1_phase_in = 1'b1;
      end else if (s1_done) begin
         s1_phase_in = 1'b0;
      end else begin
         s1_phase_in = s1_phase_ff;
      end

      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (emit0) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
         rsp_last_in  = 1'b0;
      end else if (emit1) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = s1_pix_ff;
         rsp_last_in  = s1_flags_ff.last_col;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Stage and result control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payload, loaded on each accepted pixel.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff   <= req_tdata[DEPTH_BITS-1:0];
         s1_col_ff   <= c_sel;
         s1_flags_ff <= flags;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Left-hand neighbors move on once a pixel has been written back.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff       <= '0;
         above_left_ff <= '0;
         two_left_ff   <= '0;
      end else if (step0) begin
         left_ff       <= s1_pix_ff;
         above_left_ff <= above_c;
         two_left_ff   <= two_c;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TW'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sim/tb_depth_zero_neighbor_erosion.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for depth_zero_neighbor_erosion
// Streams depth frames through the block and checks every filtered pixel
// against a cycle-free model of the 3x3 zero-neighbor erosion with one row of
// delay. Directed frames cover the extreme and clamped frame sizes, the skipped
// lower-right neighbor, the last-row passthrough and resizing in mid-frame.
// Random frames of random size and zero density follow under three idling
// patterns on the input and result streams.
// ----------------------------------------------------------------------------
module tb_depth_zero_neighbor_erosion;
   import dzne_pkg::*;

   localparam int LINE_LEN    = 512;
   localparam int DEPTH_W     = 16;
   localparam int HOLD_OFF    = 4;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic               frame_end;
   } eroded_pixel_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DEPTH_W-1:0]    req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DEPTH_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_data;

   depth_zero_neighbor_erosion #(
      .MAX_COLUMNS(LINE_LEN),
      .DEPTH_BITS (DEPTH_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),    // depth_in
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),    // depth_out
      .rsp_tlast (rsp_tlast),    // frame_end
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_addr  (csr_addr),
      .csr_data  (csr_data)
   );

   // Erosion model state: size registers, line buffers, holds and position.
   logic [COLCFG_W-1:0] cfg_columns;
   logic [ROW_W-1:0]    cfg_rows;
   logic [DEPTH_W-1:0]  line_above [LINE_LEN];
   logic [DEPTH_W-1:0]  line_two_above [LINE_LEN];
   logic [DEPTH_W-1:0]  left_px;
   logic [DEPTH_W-1:0]  above_left_px;
   logic [DEPTH_W-1:0]  two_above_left_px;
   int                  col_pos;
   int                  row_pos;

   eroded_pixel_type pending_pixels[$];
   int               mismatch_count;
   int               send_idle_pct;
   int               recv_idle_pct;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: accept with a random stall rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each result transfer with the oldest expected pixel.
   always @(posedge clock) begin
      eroded_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("rsp transfer with no result expected: depth_out %h, frame_end %b",
                   rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata !== want.depth) begin
               $error("depth_out mismatch: expected %h, actual %h", want.depth, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.frame_end) begin
               $error("frame_end mismatch: expected %b, actual %b",
                      want.frame_end, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("depth_zero_neighbor_erosion verification failed");
      $finish;
   end

   // Work out the results caused by one accepted pixel and advance the state.
   function automatic void erode_pixel(input logic [DEPTH_W-1:0] px);
      int                 cols;
      int                 rows;
      int                 c;
      int                 r;
      bit                 last_col;
      bit                 last_row;
      bit                 interior;
      bit                 hole;
      logic [DEPTH_W-1:0] above;
      logic [DEPTH_W-1:0] two_above;
      logic [DEPTH_W-1:0] above_next;
      logic [DEPTH_W-1:0] two_above_next;
      eroded_pixel_type   item;
      cols = int'(cfg_columns);
      if (cols < MIN_SIZE) cols = MIN_SIZE;
      if (cols > LINE_LEN) cols = LINE_LEN;
      rows = int'(cfg_rows);
      if (rows < MIN_SIZE) rows = MIN_SIZE;
      // A position past a shrunken frame counts as its last row or column.
      c = (col_pos < cols - 1) ? col_pos : cols - 1;
      r = (row_pos < rows - 1) ? row_pos : rows - 1;
      last_col = (c == cols - 1);
      last_row = (r == rows - 1);
      above = line_above[c];
      two_above = line_two_above[c];
      above_next = (c + 1 < LINE_LEN) ? line_above[c + 1] : '0;
      two_above_next = (c + 1 < LINE_LEN) ? line_two_above[c + 1] : '0;

      if (r >= 1) begin
         // The lower-right neighbor is not part of the test.
         interior = (r >= 2) && (c >= 1) && !last_col;
         hole = (two_above_left_px == 0) || (two_above == 0) || (two_above_next == 0) ||
                (above_left_px == 0) || (above_next == 0) || (left_px == 0) || (px == 0);
         item.depth = (interior && above != 0 && hole) ? '0 : above;
         item.frame_end = 1'b0;
         pending_pixels.push_back(item);
         // On the last row the pixel itself follows.
         if (last_row) begin
            item.depth = px;
            item.frame_end = last_col;
            pending_pixels.push_back(item);
         end
      end

      two_above_left_px = two_above;
      above_left_px = above;
      left_px = px;
      line_two_above[c] = above;
      line_above[c] = px;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   // Send one pixel after a random number of idle cycles.
   task automatic send_pixel(input logic [DEPTH_W-1:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      erode_pixel(px);
   endtask

   // Hold the input until every expected result is out and the block is idle.
   task automatic pause_for_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // Write both size registers back to back; valid stays high between them.
   task automatic write_frame_size(input logic [CSR_DATA_W-1:0] columns_val,
                                   input logic [CSR_DATA_W-1:0] rows_val);
      csr_valid <= 1'b1;
      csr_addr <= CSR_FRAME_COLUMNS;
      csr_data <= columns_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_columns = columns_val[COLCFG_W-1:0];
      csr_addr <= CSR_FRAME_ROWS;
      csr_data <= rows_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_rows = rows_val[ROW_W-1:0];
      csr_valid <= 1'b0;
   endtask

   function automatic logic [DEPTH_W-1:0] draw_depth(input int zero_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < zero_pct) return '0;
      if (roll < zero_pct + 8) return '1;
      if (roll < zero_pct + 14) return 16'h0001;
      return DEPTH_W'($urandom);
   endfunction

   // Column register value, upper bits random since the register ignores them.
   function automatic logic [CSR_DATA_W-1:0] draw_columns();
      logic [COLCFG_W-1:0] value;
      value = ($urandom_range(99) < 80) ? COLCFG_W'($urandom_range(0, 12)) :
                                          COLCFG_W'($urandom_range(13, 40));
      return {2'($urandom_range(3)), value};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] draw_rows();
      return ($urandom_range(99) < 85) ? CSR_DATA_W'($urandom_range(0, 8)) :
                                         CSR_DATA_W'($urandom_range(9, 20));
   endfunction

   // Widest frame with both registers out of range: 1023 columns clamp to the
   // line length and zero rows clamp to three. Every line buffer entry is
   // written here, so later resizing never reads an unwritten entry.
   task automatic test_wide_frame_clamp();
      write_frame_size(12'hFFF, 12'd0);
      repeat (LINE_LEN * MIN_SIZE) send_pixel(draw_depth(4));
      pause_for_idle();
   endtask

   // Six rows of three columns; the interior column checks single zeros.
   task automatic test_neighbor_pattern();
      logic [DEPTH_W-1:0] pattern [18];
      pattern = '{16'hFFFF, 16'h0001, 16'h8000,
                  16'h0001, 16'hFFFF, 16'h0001,   // kept: only lower-right is zero
                  16'h8000, 16'h0001, 16'h0000,   // cleared: right neighbor is zero
                  16'hFFFF, 16'h0001, 16'hFFFF,   // cleared: upper-right and below zero
                  16'h0001, 16'h0000, 16'h8000,   // zero center stays zero
                  16'hFFFF, 16'h8000, 16'h0001};  // last row passes through
      write_frame_size(12'd3, 12'd6);
      foreach (pattern[i]) send_pixel(pattern[i]);
      pause_for_idle();
   endtask

   // Shrink the frame while a row or a frame is under way.
   task automatic test_resize_mid_frame();
      // Columns: 6 (upper register bits ignored), cut to 3 in the middle of row 1.
      write_frame_size(12'hC06, 12'd3);
      repeat (8) send_pixel(draw_depth(10));
      pause_for_idle();
      write_frame_size(12'd3, 12'd3);
      repeat (4) send_pixel(draw_depth(10));
      pause_for_idle();
      // Rows: the largest count, cut to 3 once row 3 is due.
      write_frame_size(12'd3, 12'd4095);
      repeat (9) send_pixel(draw_depth(10));
      pause_for_idle();
      write_frame_size(12'd3, 12'd3);
      repeat (3) send_pixel(draw_depth(10));
      pause_for_idle();
   endtask

   // Whole frames of random size and density, some resized in mid-frame.
   task automatic test_random_frames(input int pixel_goal);
      int  sent;
      int  count;
      int  resize_at;
      int  zero_pct;
      bit  frame_done;
      sent = 0;
      while (sent < pixel_goal) begin
         pause_for_idle();
         write_frame_size(draw_columns(), draw_rows());
         zero_pct = $urandom_range(0, 30);
         resize_at = ($urandom_range(5) == 0) ? $urandom_range(1, 40) : -1;
         count = 0;
         frame_done = 1'b0;
         while (!frame_done) begin
            if (count == resize_at) begin
               pause_for_idle();
               write_frame_size(draw_columns(), draw_rows());
            end
            send_pixel(draw_depth(zero_pct));
            count++;
            sent++;
            frame_done = (col_pos == 0 && row_pos == 0);
         end
      end
   endtask

   // Main sequence.
   initial begin
      mismatch_count = 0;
      send_idle_pct = 12;
      recv_idle_pct = 72;
      cfg_columns = 10'd320;
      cfg_rows = 12'd240;
      foreach (line_above[i]) begin
         line_above[i] = '0;
         line_two_above[i] = '0;
      end
      left_px = '0;
      above_left_px = '0;
      two_above_left_px = '0;
      col_pos = 0;
      row_pos = 0;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_addr <= CSR_FRAME_COLUMNS;
      csr_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_wide_frame_clamp();
      test_neighbor_pattern();
      test_resize_mid_frame();
      test_random_frames(40);
      send_idle_pct = 72;
      recv_idle_pct = 12;
      test_random_frames(40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(40);

      // Drain the last results, then give the block time to show extras.
      pause_for_idle();
      repeat (2 * HOLD_OFF) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("depth_zero_neighbor_erosion verification clean");
      else
         $display("depth_zero_neighbor_erosion verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/dzne_pkg.sv
rtl/dzne_line_mem.sv
rtl/depth_zero_neighbor_erosion.sv
sim/tb_depth_zero_neighbor_erosion.sv
